// File: src/xtea_pkg.sv
// Package for the XTEA block cipher: transaction payload types, key bank type,
// register indexes, action codes and the round mixing function.
// No dependencies.
package xtea_pkg;

   localparam int WORD_WIDTH = 32;
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int KEY_WORDS = 4;

   localparam logic [WORD_WIDTH-1:0] DELTA = 32'h9e37_79b9;

   localparam logic ACTION_ENCRYPT = 1'b0;
   localparam logic ACTION_DECRYPT = 1'b1;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_KEY_WORD_0 = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_KEY_WORD_1 = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_KEY_WORD_2 = 8'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_KEY_WORD_3 = 8'd3;

   typedef struct packed {
      logic                  action;
      logic [WORD_WIDTH-1:0] block_first;
      logic [WORD_WIDTH-1:0] block_second;
   } req_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] out_first;
      logic [WORD_WIDTH-1:0] out_second;
   } rsp_type;

   typedef struct packed {
      logic                  action;
      logic [WORD_WIDTH-1:0] first;
      logic [WORD_WIDTH-1:0] second;
   } stage_type;

   typedef logic [KEY_WORDS-1:0][WORD_WIDTH-1:0] key_array_type;

   function automatic logic [WORD_WIDTH-1:0] xtea_mix(input logic [WORD_WIDTH-1:0] w);
      return ((w << 4) ^ (w >> 5)) + w;
   endfunction

endpackage

// File: src/xtea_key_regs.sv
// Key register bank: four 32-bit key words written through the csr channel.
// Depends on xtea_pkg.
module xtea_key_regs import xtea_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [WORD_WIDTH-1:0]      csr_data,
   output key_array_type              keys
);

   key_array_type keys_ff;
   key_array_type keys_in;

   always_comb begin
      keys_in = keys_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_KEY_WORD_0: keys_in[0] = csr_data;
            REG_KEY_WORD_1: keys_in[1] = csr_data;
            REG_KEY_WORD_2: keys_in[2] = csr_data;
            REG_KEY_WORD_3: keys_in[3] = csr_data;
            default:        keys_in = keys_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keys_ff <= '0;
      end else begin
         keys_ff <= keys_in;
      end
   end

   assign keys = keys_ff;

endmodule

// File: src/xtea_half_round.sv
// One pipeline stage of XTEA: a single half-round, encrypt or decrypt, with the
// round sum fixed by the stage position. Depends on xtea_pkg.
module xtea_half_round import xtea_pkg::*; #(
   parameter int CYCLES = 32,
   parameter int ROUND  = 0,
   parameter int HALF   = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          enable,
   input  key_array_type keys,
   input  logic          valid_i,
   input  stage_type     data_i,
   output logic          valid_o,
   output stage_type     data_o
);

   localparam logic [WORD_WIDTH-1:0] ENC_SUM = 32'(DELTA * 32'(ROUND + HALF));
   localparam logic [WORD_WIDTH-1:0] DEC_SUM = 32'(DELTA * 32'(CYCLES - ROUND - HALF));
   localparam logic [1:0] ENC_SEL = (HALF == 0) ? ENC_SUM[1:0] : ENC_SUM[12:11];
   localparam logic [1:0] DEC_SEL = (HALF == 0) ? DEC_SUM[12:11] : DEC_SUM[1:0];

   logic                  valid_ff;
   stage_type             data_ff;
   stage_type             data_in;
   logic                  is_dec;
   logic                  upd_first;
   logic [WORD_WIDTH-1:0] src_word;
   logic [WORD_WIDTH-1:0] dst_word;
   logic [WORD_WIDTH-1:0] round_sum;
   logic [1:0]            key_sel;
   logic [WORD_WIDTH-1:0] feedback;
   logic [WORD_WIDTH-1:0] result;

   always_comb begin
      is_dec    = (data_i.action == ACTION_DECRYPT);
      upd_first = is_dec ? (HALF == 1) : (HALF == 0);
      src_word  = upd_first ? data_i.second : data_i.first;
      dst_word  = upd_first ? data_i.first : data_i.second;
      round_sum = is_dec ? DEC_SUM : ENC_SUM;
      key_sel   = is_dec ? DEC_SEL : ENC_SEL;
      feedback  = xtea_mix(src_word) ^ (round_sum + keys[key_sel]);
      result    = is_dec ? (dst_word - feedback) : (dst_word + feedback);
      data_in   = data_i;
      if (upd_first) begin
         data_in.first = result;
      end else begin
         data_in.second = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign valid_o = valid_ff;
   assign data_o  = data_ff;

endmodule

// File: src/xtea_block_cipher.sv
// XTEA block cipher top level: key bank and a pipeline of 2*CYCLES half-round stages.
// Depends on xtea_pkg, xtea_key_regs, xtea_half_round.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_ready  | req_data  (req_type)
//   rsp     | out       | rsp_valid / rsp_ready  | rsp_data  (rsp_type)
//   csr     | in        | csr_valid / csr_ready  | csr_index, csr_data
//
// Each stage computes one half-round.
// Throughput is one transaction per cycle; the last stage is the output register.
// The whole pipeline advances together; it holds when the output is full and not taken.
// Synchronous reset clears the valid bits and the key words; csr_ready is always high.
module xtea_block_cipher import xtea_pkg::*; #(
   parameter int CYCLES = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_type                    rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [WORD_WIDTH-1:0]      csr_data
);

   localparam int STAGES = 2 * CYCLES;

   key_array_type keys;
   logic          enable;
   logic          valid_chain [STAGES+1];
   stage_type     data_chain  [STAGES+1];

   xtea_key_regs u_keys (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .keys      (keys)
   );

   assign enable    = !valid_chain[STAGES] || rsp_ready;
   assign req_ready = enable;
   assign csr_ready = 1'b1;

   assign valid_chain[0]       = req_valid;
   assign data_chain[0].action = req_data.action;
   assign data_chain[0].first  = req_data.block_first;
   assign data_chain[0].second = req_data.block_second;

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      xtea_half_round #(
         .CYCLES (CYCLES),
         .ROUND  (s / 2),
         .HALF   (s % 2)
      ) u_half (
         .clock   (clock),
         .reset   (reset),
         .enable  (enable),
         .keys    (keys),
         .valid_i (valid_chain[s]),
         .data_i  (data_chain[s]),
         .valid_o (valid_chain[s+1]),
         .data_o  (data_chain[s+1])
      );
   end

   assign rsp_valid           = valid_chain[STAGES];
   assign rsp_data.out_first  = data_chain[STAGES].first;
   assign rsp_data.out_second = data_chain[STAGES].second;

endmodule

// File: dv/xtea_block_cipher_checker.sv
`timescale 1ns / 1ps
// Scoreboard for xtea_block_cipher: mirrors the key registers from the csr channel,
// predicts every block transaction and compares each result transaction in order.
// Depends on xtea_pkg.
module xtea_block_cipher_checker import xtea_pkg::*; #(
   parameter int CYCLES = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  req_type                    req_data,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  rsp_type                    rsp_data,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [WORD_WIDTH-1:0]      csr_data,
   output int                         fail_count,
   output int                         open_count,
   output int                         checked_count
);

   logic [WORD_WIDTH-1:0] key_bank [KEY_WORDS];
   rsp_type               expected_blocks [$];

   function automatic logic [WORD_WIDTH-1:0] feistel_mix(input logic [WORD_WIDTH-1:0] w);
      return ((w << 4) ^ (w >> 5)) + w;
   endfunction

   function automatic rsp_type cipher_block(input req_type item);
      logic [WORD_WIDTH-1:0] v0;
      logic [WORD_WIDTH-1:0] v1;
      logic [WORD_WIDTH-1:0] total;
      rsp_type               result;
      v0 = item.block_first;
      v1 = item.block_second;
      if (item.action == ACTION_ENCRYPT) begin
         total = '0;
         for (int n = 0; n < CYCLES; n++) begin
            v0 = v0 + (feistel_mix(v1) ^ (total + key_bank[total[1:0]]));
            total = total + DELTA;
            v1 = v1 + (feistel_mix(v0) ^ (total + key_bank[total[12:11]]));
         end
      end else begin
         // decipher starts from the final encipher sum, wrapped to 32 bits
         total = DELTA * WORD_WIDTH'(CYCLES);
         for (int n = 0; n < CYCLES; n++) begin
            v1 = v1 - (feistel_mix(v0) ^ (total + key_bank[total[12:11]]));
            total = total - DELTA;
            v0 = v0 - (feistel_mix(v1) ^ (total + key_bank[total[1:0]]));
         end
      end
      result.out_first = v0;
      result.out_second = v1;
      return result;
   endfunction

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         for (int k = 0; k < KEY_WORDS; k++) key_bank[k] = '0;
         expected_blocks.delete();
         fail_count = 0;
         checked_count = 0;
      end else begin
         if (csr_valid && csr_ready && csr_index <= REG_KEY_WORD_3)
            key_bank[csr_index[1:0]] = csr_data;
         if (rsp_valid && rsp_ready) begin
            if (expected_blocks.size() == 0) begin
               $error("result transaction with no block pending: %h", rsp_data);
               fail_count++;
            end else begin
               want = expected_blocks.pop_front();
               checked_count++;
               if (rsp_data.out_first !== want.out_first) begin
                  $error("out_first: expected %h, actual %h", want.out_first,
                         rsp_data.out_first);
                  fail_count++;
               end
               if (rsp_data.out_second !== want.out_second) begin
                  $error("out_second: expected %h, actual %h", want.out_second,
                         rsp_data.out_second);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready)
            expected_blocks.push_back(cipher_block(req_data));
      end
      open_count = expected_blocks.size();
   end

endmodule

// File: dv/tb_xtea_block_cipher.sv
`timescale 1ns / 1ps
// Testbench top for xtea_block_cipher: clock, reset, key loads, block stimulus with
// random idling and long output stalls; the verdict comes from the checker's count.
// Depends on xtea_pkg, xtea_block_cipher, xtea_block_cipher_checker.
module tb_xtea_block_cipher;
   import xtea_pkg::*;

   localparam int CYCLES = 32;
   localparam int LATENCY = 2 * CYCLES;
   localparam int PHASES = 6;
   localparam int RANDOM_BLOCKS = 300;
   localparam int HOLD_CYCLES = 300;
   localparam int IDLE_PERCENT = 34;
   localparam logic [CSR_INDEX_WIDTH-1:0] UNMAPPED_INDEX_LOW = REG_KEY_WORD_3 + 1'b1;
   localparam logic [CSR_INDEX_WIDTH-1:0] UNMAPPED_INDEX_TOP = '1;

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   req_type                    req_data = '0;
   logic                       rsp_valid;
   logic                       rsp_ready;
   rsp_type                    rsp_data;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [WORD_WIDTH-1:0]      csr_data = '0;

   bit calm_mode = 1'b0;
   int holds_asked = 0;
   int holds_done = 0;
   int fail_count;
   int open_count;
   int checked_count;
   int encrypt_count = 0;
   int decrypt_count = 0;
   int key_settings = 1;

   xtea_block_cipher #(.CYCLES(CYCLES)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   xtea_block_cipher_checker #(.CYCLES(CYCLES)) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .open_count    (open_count),
      .checked_count (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #200000;
      $display("simulation failed");
      $finish;
   end

   // output side: random backpressure, plus long hold-offs on request
   initial begin : receiver
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (holds_done < holds_asked) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            holds_done++;
         end else begin
            rsp_ready <= calm_mode || ($urandom_range(99) >= IDLE_PERCENT);
            @(negedge clock);
         end
      end
   end

   function automatic logic [WORD_WIDTH-1:0] pick_word();
      unique case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return $urandom();
      endcase
   endfunction

   task automatic send_block(input logic action, input logic [WORD_WIDTH-1:0] first,
                             input logic [WORD_WIDTH-1:0] second);
      req_type item;
      item.action = action;
      item.block_first = first;
      item.block_second = second;
      while (!calm_mode && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      if (action == ACTION_ENCRYPT) encrypt_count++;
      else decrypt_count++;
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [WORD_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // stop offering blocks and wait until every result has come back
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (open_count != 0);
   endtask

   task automatic load_keys(input logic [WORD_WIDTH-1:0] k0, input logic [WORD_WIDTH-1:0] k1,
                            input logic [WORD_WIDTH-1:0] k2, input logic [WORD_WIDTH-1:0] k3);
      drain();
      write_csr(UNMAPPED_INDEX_LOW, $urandom());
      write_csr(REG_KEY_WORD_0, k0);
      write_csr(REG_KEY_WORD_1, k1);
      write_csr(REG_KEY_WORD_2, k2);
      write_csr(REG_KEY_WORD_3, k3);
      write_csr(UNMAPPED_INDEX_TOP, $urandom());
      csr_valid <= 1'b0;
      key_settings++;
   endtask

   task automatic send_corners();
      logic act;
      for (int a = 0; a < 2; a++) begin
         act = (a == 0) ? ACTION_ENCRYPT : ACTION_DECRYPT;
         send_block(act, '0, '0);
         send_block(act, '1, '1);
         send_block(act, '0, '1);
         send_block(act, '1, '0);
         send_block(act, 32'h8000_0000, 32'h0000_0001);
         send_block(act, 32'ha5a5_a5a5, 32'h5a5a_5a5a);
      end
   endtask

   initial begin : stimulus
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset keys, then all-ones keys
      send_corners();
      load_keys('1, '1, '1, '1);
      send_corners();

      for (int p = 0; p < PHASES; p++) begin
         unique case (p)
            1: load_keys(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
            3: load_keys('1, '0, '0, '1);
            5: load_keys('0, '0, '0, '0);
            default: load_keys(pick_word(), pick_word(), pick_word(), pick_word());
         endcase
         calm_mode = (p == 2);
         if (p == 1 || p == 4) holds_asked++;
         for (int n = 0; n < RANDOM_BLOCKS; n++)
            send_block(1'($urandom_range(1)), pick_word(), pick_word());
         calm_mode = 1'b0;
      end

      drain();
      repeat (LATENCY) @(negedge clock);
      $display("covered %0d encrypt and %0d decrypt blocks under %0d key settings",
               encrypt_count, decrypt_count, key_settings);
      $display("%0d results compared, %0d long output stalls", checked_count, holds_done);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: xtea_block_cipher.f
src/xtea_pkg.sv
src/xtea_key_regs.sv
src/xtea_half_round.sv
src/xtea_block_cipher.sv
dv/xtea_block_cipher_checker.sv
dv/tb_xtea_block_cipher.sv
